// File: sv/mpqa_pkg.sv
// Shared types and constants for the min-priority queue array unit.
package mpqa_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        t_status                  status;
        logic [CNT_W-1:0]         count;
    } t_result;

endpackage

// File: sv/mpqa_mem.sv
// Entry store: one write port and one registered read port.
module mpqa_mem (
    input  logic                          i_clk,
    input  mpqa_pkg::t_mem_req            i_req,
    output logic [mpqa_pkg::DATA_W-1:0]   o_rd_data
);

    logic [mpqa_pkg::DATA_W-1:0] r_mem [mpqa_pkg::CAPACITY];
    logic [mpqa_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/mpqa_ctrl.sv
// Sequencer: append, minimum scan and shift-down over the entry store.
module mpqa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic signed [31:0]            i_value,
    output mpqa_pkg::t_mem_req            o_mem_req,
    input  logic [mpqa_pkg::DATA_W-1:0]   i_rd_data,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output mpqa_pkg::t_result             o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic [mpqa_pkg::CNT_W-1:0]          r_count, n_count;
    logic [mpqa_pkg::ADDR_W-1:0]         r_idx, n_idx;
    logic [mpqa_pkg::ADDR_W-1:0]         r_best, n_best;
    logic signed [mpqa_pkg::DATA_W-1:0]  r_min, n_min;
    mpqa_pkg::t_status                   r_status, n_status;

    logic signed [mpqa_pkg::DATA_W-1:0]  rd_val;
    logic                                take;
    logic                                last;
    logic                                best_last;
    logic [mpqa_pkg::ADDR_W-1:0]         cand_best;
    logic signed [mpqa_pkg::DATA_W-1:0]  cand_min;
    mpqa_pkg::t_mem_req                  req;

    assign rd_val    = $signed(i_rd_data);
    assign take      = (r_idx == '0) || (rd_val < r_min);
    assign cand_best = take ? r_idx : r_best;
    assign cand_min  = take ? rd_val : r_min;
    assign last      = ({1'b0, r_idx} + 1'b1) == r_count;
    assign best_last = ({1'b0, cand_best} + 1'b1) == r_count;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_best   = r_best;
        n_min    = r_min;
        n_status = r_status;
        req      = '0;
        o_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_min    = '0;
                    n_status = mpqa_pkg::ST_OK;
                    n_state  = S_DONE;
                    if (i_opcode == mpqa_pkg::OP_INSERT) begin
                        if (r_count == mpqa_pkg::CNT_W'(mpqa_pkg::CAPACITY)) begin
                            n_status = mpqa_pkg::ST_OVERFLOW;
                        end else begin
                            req.wr_en   = 1'b1;
                            req.wr_addr = r_count[mpqa_pkg::ADDR_W-1:0];
                            req.wr_data = i_value;
                            n_count     = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_status = mpqa_pkg::ST_UNDERFLOW;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = '0;
                        n_idx       = '0;
                        n_best      = '0;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_min  = cand_min;
                n_best = cand_best;
                if (!last) begin
                    n_idx       = r_idx + 1'b1;
                    req.rd_en   = 1'b1;
                    req.rd_addr = n_idx;
                end else if (best_last) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_idx       = cand_best + 1'b1;
                    req.rd_en   = 1'b1;
                    req.rd_addr = n_idx;
                    n_state     = S_SHIFT;
                end
            end
            S_SHIFT: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_idx - 1'b1;
                req.wr_data = i_rd_data;
                if (last) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_idx       = r_idx + 1'b1;
                    req.rd_en   = 1'b1;
                    req.rd_addr = n_idx;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_best   <= n_best;
        r_min    <= n_min;
        r_status <= n_status;
    end

    assign o_mem_req           = req;
    assign o_res_valid         = (r_state == S_DONE);
    assign o_res.removed_value = r_min;
    assign o_res.status        = r_status;
    assign o_res.count         = r_count;

`ifndef ASSERT_OFF
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr)))
        else $error("read and write hit the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mpqa_pkg::CNT_W'(mpqa_pkg::CAPACITY))
        else $error("fill count beyond capacity");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} < r_count))
        else $error("scan index beyond fill count");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx != '0 && {1'b0, r_idx} < r_count
                                  && r_best < r_idx))
        else $error("shift index out of range");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN || r_state == S_SHIFT) && n_state == S_DONE)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("remove did not drop one entry");
`endif

endmodule

// File: sv/min_priority_queue_array_unit.sv
// Top level of the min-priority queue array unit with its output register.
//
// Input channel: i_valid/o_ready carry one word of i_opcode (0 insert,
// 1 remove smallest) and i_value (signed 32-bit, ignored on remove).
// Output channel: o_valid/i_ready carry one word per input word:
// o_removed_value, o_status (0 ok, 1 overflow, 2 underflow) and o_count,
// the number of entries held afterwards.
// Entries live in a 64-entry store with one write and one registered read
// port. An insert, an overflow or an underflow goes from accept straight to
// the result. A remove with n entries held scans all n entries, reading one
// entry a cycle, to find the smallest (the first wins a tie); then later
// entries move down one a cycle through the same read and write ports.
// The next word is accepted as soon as the previous result sits in the
// output register; a stalled receiver holds that register and, once a
// second result is ready, holds the sequencer too.
// Reset (synchronous, active low) empties the queue and drops any word in
// flight; store contents are not cleared.
module min_priority_queue_array_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_removed_value,
    output logic [1:0]         o_status,
    output logic [6:0]         o_count
);

    mpqa_pkg::t_mem_req                mem_req;
    logic [mpqa_pkg::DATA_W-1:0]       rd_data;
    logic                              res_valid;
    logic                              res_take;
    mpqa_pkg::t_result                 res;

    logic                              r_out_valid;
    mpqa_pkg::t_result                 r_out;

    mpqa_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    mpqa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    assign res_take = res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_out.removed_value;
    assign o_status        = r_out.status;
    assign o_count         = 7'(r_out.count);

endmodule

// File: dv/min_priority_queue_array_unit_tb.sv
// Testbench for the min-priority queue array unit: directed table, then random words.
`timescale 1ns / 1ps

module min_priority_queue_array_unit_tb;

    localparam int RANDOM_WORDS = 450;
    localparam int PHASE_WORDS  = 75;
    localparam int DRAIN_CYCLES = 2 * mpqa_pkg::CAPACITY + 12;

    typedef struct packed {
        logic               op;
        logic signed [31:0] val;
        bit                 typed;
        mpqa_pkg::t_result  res;
    } t_row;

    localparam int DIRECTED_ROWS = 20;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, mpqa_pkg::ST_UNDERFLOW, 7'd0}},
        '{mpqa_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1,
          '{32'h0000_0000, mpqa_pkg::ST_OK, 7'd1}},
        '{mpqa_pkg::OP_INSERT, 32'h8000_0000, 1'b1,
          '{32'h0000_0000, mpqa_pkg::ST_OK, 7'd2}},
        '{mpqa_pkg::OP_INSERT, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, mpqa_pkg::ST_OK, 7'd3}},
        '{mpqa_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, mpqa_pkg::ST_OK, 7'd4}},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
          '{32'h8000_0000, mpqa_pkg::ST_OK, 7'd3}},
        '{mpqa_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0},
        '{mpqa_pkg::OP_INSERT, 32'hFFFF_FFFD, 1'b0, '0},
        '{mpqa_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0},
        '{mpqa_pkg::OP_INSERT, 32'hFFFF_FFFD, 1'b0, '0},
        '{mpqa_pkg::OP_REMOVE, 32'hAAAA_AAAA, 1'b0, '0},
        '{mpqa_pkg::OP_REMOVE, 32'h5555_5555, 1'b0, '0},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
          '{32'h7FFF_FFFF, mpqa_pkg::ST_OK, 7'd0}},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, mpqa_pkg::ST_UNDERFLOW, 7'd0}},
        '{mpqa_pkg::OP_INSERT, 32'h8000_0000, 1'b1,
          '{32'h0000_0000, mpqa_pkg::ST_OK, 7'd1}},
        '{mpqa_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
          '{32'h8000_0000, mpqa_pkg::ST_OK, 7'd0}}
    };

    localparam int INSERT_PCT [6] = '{95, 50, 5, 90, 50, 10};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_opcode = mpqa_pkg::OP_INSERT;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_removed_value;
    logic [1:0]         o_status;
    logic [6:0]         o_count;

    logic signed [31:0] held_entries [$];
    mpqa_pkg::t_result  pending_results [$];
    int                 fault_count = 0;
    bit                 gaps_on = 1'b1;

    min_priority_queue_array_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_count         (o_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic mpqa_pkg::t_result apply_queue_op(logic op,
                                                         logic signed [31:0] val);
        mpqa_pkg::t_result r;
        int                best;
        r.removed_value = '0;
        r.status        = mpqa_pkg::ST_OK;
        if (op == mpqa_pkg::OP_INSERT) begin
            if (held_entries.size() >= mpqa_pkg::CAPACITY) begin
                r.status = mpqa_pkg::ST_OVERFLOW;
            end else begin
                held_entries.push_back(val);
            end
        end else if (held_entries.size() == 0) begin
            r.status = mpqa_pkg::ST_UNDERFLOW;
        end else begin
            best = 0;
            for (int i = 1; i < held_entries.size(); i++) begin
                if (held_entries[i] < held_entries[best]) begin
                    best = i;
                end
            end
            r.removed_value = held_entries[best];
            held_entries.delete(best);
        end
        r.count = mpqa_pkg::CNT_W'(held_entries.size());
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return $urandom;
        end else if (sel < 9) begin
            return $signed($urandom_range(0, 15)) - 8;
        end else begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
    endfunction

    task automatic send_word(input logic op, input logic signed [31:0] val,
                             input bit typed, input mpqa_pkg::t_result typed_res);
        mpqa_pkg::t_result predicted;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        predicted = apply_queue_op(op, val);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    always @(negedge i_clk) begin
        i_ready <= gaps_on ? ($urandom_range(0, 99) >= 9) : 1'b1;
    end

    always @(posedge i_clk) begin
        mpqa_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected word: removed_value %0d status %0d count %0d",
                         $time, o_removed_value, o_status, o_count);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_removed_value !== want.removed_value) begin
                    $display("%0t removed_value expected %0d got %0d",
                             $time, want.removed_value, o_removed_value);
                    fault_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t status expected %0d got %0d", $time, want.status, o_status);
                    fault_count++;
                end
                if (o_count !== want.count) begin
                    $display("%0t count expected %0d got %0d", $time, want.count, o_count);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        logic op;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            send_word(DIRECTED[r].op, DIRECTED[r].val, DIRECTED[r].typed, DIRECTED[r].res);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gaps_on = (n / PHASE_WORDS) != 3;
            op = ($urandom_range(0, 99) < INSERT_PCT[(n / PHASE_WORDS) % 6]) ?
                 mpqa_pkg::OP_INSERT : mpqa_pkg::OP_REMOVE;
            send_word(op, pick_value(), 1'b0, '0);
        end
        gaps_on = 1'b1;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("PASS min_priority_queue_array_unit");
        end else begin
            $display("FAIL min_priority_queue_array_unit");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL min_priority_queue_array_unit");
        $finish;
    end

endmodule

// File: files.f
sv/mpqa_pkg.sv
sv/mpqa_mem.sv
sv/mpqa_ctrl.sv
sv/min_priority_queue_array_unit.sv
dv/min_priority_queue_array_unit_tb.sv
